>>> design/pidhb_pkg.sv
`default_nettype none

package pidhb_pkg;

  localparam int CFG_W   = 16;
  localparam int CFG_IDX = 3;
  localparam int CNT_W   = 16;
  localparam int GAIN_W  = 10;
  localparam int ERR_W   = 18;
  localparam int DER_W   = 19;
  localparam int SUM_W   = 32;
  localparam int DRV_W   = 16;

  localparam logic signed [15:0] SETPOINT_RST = 16'sd10000;
  localparam logic [GAIN_W-1:0]  KP_RST       = 10'd80;
  localparam logic [GAIN_W-1:0]  KD_RST       = 10'd3;
  localparam logic [GAIN_W-1:0]  KI_RST       = 10'd10;
  localparam logic [15:0]        ZONE_RST     = 16'd320;
  localparam logic [15:0]        LIMIT_RST    = 16'd26667;
  localparam logic [15:0]        CENTER_RST   = 16'hFFFF / 16'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_PROP  = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_GAIN_INTEG = 3'd3,
    REG_ZONE       = 3'd4,
    REG_LIMIT      = 3'd5,
    REG_CENTER     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [GAIN_W-1:0]  gain_integ;
    logic [15:0]        integral_zone;
    logic [15:0]        pwm_limit;
    logic [15:0]        encoder_center;
  } cfg_t;

  // error terms handed from the error stage to the control-law stage
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W-1:0] deriv;
    logic signed [SUM_W-1:0] integ;
  } terms_t;

endpackage

`default_nettype wire

>>> design/pidhb_cfg.sv
`default_nettype none

module pidhb_cfg
  import pidhb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IDX-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:   cfg_nxt.setpoint       = $signed(cfg_wdata);
        REG_GAIN_PROP:  cfg_nxt.gain_prop      = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV: cfg_nxt.gain_deriv     = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG: cfg_nxt.gain_integ     = cfg_wdata[GAIN_W-1:0];
        REG_ZONE:       cfg_nxt.integral_zone  = cfg_wdata;
        REG_LIMIT:      cfg_nxt.pwm_limit      = cfg_wdata;
        REG_CENTER:     cfg_nxt.encoder_center = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= SETPOINT_RST;
      cfg_r.gain_prop      <= KP_RST;
      cfg_r.gain_deriv     <= KD_RST;
      cfg_r.gain_integ     <= KI_RST;
      cfg_r.integral_zone  <= ZONE_RST;
      cfg_r.pwm_limit      <= LIMIT_RST;
      cfg_r.encoder_center <= CENTER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/pidhb_front.sv
`default_nettype none

module pidhb_front
  import pidhb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CNT_W-1:0] in_encoder_count,
  input  wire logic             take,
  output logic                  terms_valid,
  output terms_t                terms
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [CNT_W-1:0]  s1_count_r;
  logic              s2_valid_r, s2_valid_nxt;
  terms_t            s2_terms_r;
  logic signed [ERR_W-1:0] last_error_r;
  logic signed [SUM_W-1:0] error_sum_r;

  logic              s2_free, s1_mv, s1_free, in_xfer;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]  abs_err;
  logic              in_zone;
  logic signed [DER_W-1:0] deriv;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] integ;

  assign s2_free  = !s2_valid_r || take;
  assign s1_mv    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_xfer  = in_valid && s1_free;

  always_comb begin
    err = $signed({2'b00, s1_count_r}) - $signed({2'b00, cfg.encoder_center})
          - $signed({{2{cfg.setpoint[15]}}, cfg.setpoint});
    abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    in_zone = abs_err < {2'b00, cfg.integral_zone};
    deriv   = $signed({err[ERR_W-1], err}) - $signed({last_error_r[ERR_W-1], last_error_r});
    sum_ext = $signed({error_sum_r[SUM_W-1], error_sum_r})
              + $signed({{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
    if (!in_zone) begin
      integ = '0;
    end else if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      // 32-bit saturation
      integ = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      integ = sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_free ? in_valid : s1_valid_r;
    if (s1_mv) begin
      s2_valid_nxt = 1'b1;
    end else if (take) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (s1_mv) begin
        last_error_r <= err;
        error_sum_r  <= integ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_count_r <= in_encoder_count;
    end
    if (s1_mv) begin
      s2_terms_r.err   <= err;
      s2_terms_r.deriv <= deriv;
      s2_terms_r.integ <= integ;
    end
  end

  assign terms_valid = s2_valid_r;
  assign terms       = s2_terms_r;

`ifndef SYNTHESIS
  a_zone_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_mv && !in_zone |=> error_sum_r == '0)
    else $error("integral not cleared outside zone");
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_mv |=> $stable(last_error_r) && $stable(error_sum_r))
    else $error("controller state changed without a transfer");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r)
    else $error("input stalled with free pipeline slot");
`endif

endmodule

`default_nettype wire

>>> design/pidhb_law.sv
`default_nettype none

module pidhb_law
  import pidhb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              terms_valid,
  input  wire terms_t            terms,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DRV_W-1:0]       out_drive_forward,
  output logic [DRV_W-1:0]       out_drive_reverse
);

  localparam int PID_W = 44;

  logic                 out_valid_r, out_valid_nxt;
  logic [DRV_W-1:0]     fwd_r, rev_r, fwd_nxt, rev_nxt;

  logic signed [28:0]   prod_p;
  logic signed [29:0]   prod_d;
  logic signed [42:0]   prod_i;
  logic signed [PID_W-1:0] pid;
  logic [PID_W-1:0]     mag;
  logic [DRV_W-1:0]     drive;
  logic                 err_pos, err_neg;

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    prod_p = $signed({1'b0, cfg.gain_prop})  * $signed(terms.err);
    prod_d = $signed({1'b0, cfg.gain_deriv}) * $signed(terms.deriv);
    prod_i = $signed({1'b0, cfg.gain_integ}) * $signed(terms.integ);
    pid = $signed({{(PID_W-29){prod_p[28]}}, prod_p})
        + $signed({{(PID_W-30){prod_d[29]}}, prod_d})
        + $signed({{(PID_W-43){prod_i[42]}}, prod_i});
    mag = pid[PID_W-1] ? PID_W'(-pid) : PID_W'(pid);
    drive = (mag > {{(PID_W-DRV_W){1'b0}}, cfg.pwm_limit}) ? cfg.pwm_limit : mag[DRV_W-1:0];
    // channel follows the sign of the error, not of the pid sum
    err_pos = !terms.err[ERR_W-1] && (terms.err != '0);
    err_neg = terms.err[ERR_W-1];
    fwd_nxt = err_pos ? drive : '0;
    rev_nxt = err_neg ? drive : '0;
    out_valid_nxt = take ? terms_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && terms_valid) begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_forward = fwd_r;
  assign out_drive_reverse = rev_r;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fwd_r == '0) || (rev_r == '0))
    else $error("both bridge sides driven");
  a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    take && terms_valid && terms.err == '0 |=> fwd_r == '0 && rev_r == '0)
    else $error("drive on zero error");
`endif

endmodule

`default_nettype wire

>>> design/pid_position_hbridge_drive_unit.sv
`default_nettype none

// Position PID controller for an H-bridge. Each transfer on the in_ channel carries one
// raw quadrature count; each out_ transfer carries the forward and reverse PWM compare
// values for it, one result per count, in order. The block takes a new count every cycle
// unless out_stall backs the pipeline up and raises in_stall; each count passes the input
// register, the error and integral stage, and the control-law stage with its output
// register. The rate is set by the error/integral update, whose registered state feeds
// straight back into its own next value. Gains, setpoint, integral zone, PWM limit and
// encoder center are written through the cfg_ port and should only change while no counts are in flight.
module pid_position_hbridge_drive_unit
  import pidhb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IDX-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CNT_W-1:0]   in_encoder_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DRV_W-1:0]        out_drive_forward,
  output logic [DRV_W-1:0]        out_drive_reverse
);

  cfg_t   cfg;
  terms_t terms;
  logic   terms_valid;
  logic   take;

  pidhb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidhb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_encoder_count (in_encoder_count),
    .take             (take),
    .terms_valid      (terms_valid),
    .terms            (terms)
  );

  pidhb_law u_law (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .terms_valid       (terms_valid),
    .terms             (terms),
    .take              (take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_forward (out_drive_forward),
    .out_drive_reverse (out_drive_reverse)
  );

endmodule

`default_nettype wire

>>> verif/pid_position_hbridge_drive_unit_test.sv
module pid_position_hbridge_drive_unit_test
  import pidhb_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int RUN_ITEMS = 8;
  // no register lives at this index; writes to it must be dropped
  localparam logic [CFG_IDX-1:0] REG_NONE = 3'd7;
  localparam longint INTEG_HI = 64'sd2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;

  typedef struct packed {
    logic [DRV_W-1:0] fwd;
    logic [DRV_W-1:0] rev;
  } drive_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CFG_IDX-1:0] idx;
    logic [CFG_W-1:0]   data;
    logic               typed;
    drive_t             drive;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [CNT_W-1:0]   in_encoder_count;
  logic               out_valid;
  logic               out_stall;
  logic [DRV_W-1:0]   out_drive_forward;
  logic [DRV_W-1:0]   out_drive_reverse;

  pid_position_hbridge_drive_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_encoder_count  (in_encoder_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_forward (out_drive_forward),
    .out_drive_reverse (out_drive_reverse)
  );

  // controller model: configuration and loop state
  int     m_setpoint;
  int     m_kp;
  int     m_kd;
  int     m_ki;
  int     m_zone;
  int     m_limit;
  int     m_center;
  longint m_last_err;
  longint m_err_sum;

  drive_t drive_q[$];
  row_t   dir_rows[$];
  int     n_mismatch;
  int     send_idle_pct;
  int     stall_pct;
  int     cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void reset_model();
    m_setpoint = int'($signed(SETPOINT_RST));
    m_kp       = int'(KP_RST);
    m_kd       = int'(KD_RST);
    m_ki       = int'(KI_RST);
    m_zone     = int'(ZONE_RST);
    m_limit    = int'(LIMIT_RST);
    m_center   = int'(CENTER_RST);
    m_last_err = 0;
    m_err_sum  = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_SETPOINT:   m_setpoint = int'($signed(data));
      REG_GAIN_PROP:  m_kp = int'(data[GAIN_W-1:0]);
      REG_GAIN_DERIV: m_kd = int'(data[GAIN_W-1:0]);
      REG_GAIN_INTEG: m_ki = int'(data[GAIN_W-1:0]);
      REG_ZONE:       m_zone = int'(data);
      REG_LIMIT:      m_limit = int'(data);
      REG_CENTER:     m_center = int'(data);
      default: ;
    endcase
  endfunction

  function automatic drive_t predict_drive(input logic [CNT_W-1:0] count);
    longint err;
    longint deriv;
    longint integ;
    longint pid;
    longint mag;
    drive_t d;
    err   = longint'(count) - longint'(m_center) - longint'(m_setpoint);
    deriv = err - m_last_err;
    if ((err < 0 ? -err : err) < longint'(m_zone)) begin
      integ = m_err_sum + err;
      if (integ > INTEG_HI) integ = INTEG_HI;
      if (integ < INTEG_LO) integ = INTEG_LO;
    end else begin
      integ = 0;
    end
    m_err_sum = integ;
    pid = longint'(m_kp) * err + longint'(m_kd) * deriv + longint'(m_ki) * integ;
    mag = pid < 0 ? -pid : pid;
    if (mag > longint'(m_limit)) mag = longint'(m_limit);
    d = '0;
    // channel follows the error sign, not the sign of the control sum
    if (err > 0) d.fwd = mag[DRV_W-1:0];
    else if (err < 0) d.rev = mag[DRV_W-1:0];
    m_last_err = err;
    return d;
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX-1:0] idx, input logic [CFG_W-1:0] data);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_item(input logic [CNT_W-1:0] count, input logic typed,
                                   input logic [DRV_W-1:0] fwd, input logic [DRV_W-1:0] rev);
    row_t r;
    r = '0;
    r.data = count;
    r.typed = typed;
    r.drive.fwd = fwd;
    r.drive.rev = rev;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg(input int width);
    logic [CFG_W-1:0] ones;
    ones = (CFG_W'(1) << width) - 1'b1;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ones;
      2: return CFG_W'($urandom_range(0, 255));
      default: return CFG_W'($urandom) & ones;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_setpoint();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return CFG_W'($urandom_range(0, 4000) - 2000);
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // mostly counts near the target so the integral and the derivative see real work
  function automatic logic [CNT_W-1:0] rand_count();
    int target;
    target = m_center + m_setpoint;
    if ($urandom_range(0, 9) < 7)
      return CNT_W'(target + int'($urandom_range(0, 1200)) - 600);
    return CNT_W'($urandom);
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        n_mismatch = n_mismatch + 1;
        $display("%0t: unexpected result expected none actual fwd=%0d rev=%0d", $time,
                 out_drive_forward, out_drive_reverse);
      end else begin
        want = drive_q.pop_front();
        if (out_drive_forward !== want.fwd) begin
          n_mismatch = n_mismatch + 1;
          $display("%0t: drive_forward expected %0d actual %0d", $time,
                   want.fwd, out_drive_forward);
        end
        if (out_drive_reverse !== want.rev) begin
          n_mismatch = n_mismatch + 1;
          $display("%0t: drive_reverse expected %0d actual %0d", $time,
                   want.rev, out_drive_reverse);
        end
      end
    end
  end

  task automatic send_count(input logic [CNT_W-1:0] count, input logic typed,
                            input drive_t typed_drive);
    drive_t d;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    d = predict_drive(count);
    drive_q.push_back(typed ? typed_drive : d);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_count(input logic [CNT_W-1:0] count, input int n);
    for (int i = 0; i < n; i++) send_count(count, 1'b0, '0);
  endtask

  initial begin
    row_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_encoder_count = '0;
    out_stall = 1'b0;
    n_mismatch = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    reset_model();

    // settings after reset: setpoint 10000, center 32767, gains 80/3/10, zone 320
    row_item(16'd42767, 1'b1, 16'd0, 16'd0);        // zero error
    row_item(16'd65535, 1'b1, 16'd26667, 16'd0);
    row_item(16'd0, 1'b1, 16'd0, 16'd26667);
    row_item(16'd42768, 1'b1, 16'd26667, 16'd0);
    row_item(16'd42768, 1'b1, 16'd100, 16'd0);
    row_item(16'd42766, 1'b1, 16'd0, 16'd76);
    row_item(16'd65535, 1'b1, 16'd26667, 16'd0);
    row_item(16'd42768, 1'b1, 16'd26667, 16'd0);    // error up, control sum down
    row_item(16'd0, 1'b1, 16'd0, 16'd26667);
    row_item(16'd42766, 1'b1, 16'd0, 16'd26667);    // error down, control sum up
    row_cfg(REG_LIMIT, 16'd0);
    row_item(16'd65535, 1'b1, 16'd0, 16'd0);
    row_item(16'd42768, 1'b1, 16'd0, 16'd0);
    row_cfg(REG_LIMIT, 16'hFFFF);
    row_cfg(REG_ZONE, 16'd0);                       // integral never runs
    row_item(16'd42768, 1'b1, 16'd80, 16'd0);
    row_item(16'd42766, 1'b1, 16'd0, 16'd86);
    row_cfg(REG_ZONE, 16'hFFFF);
    row_cfg(REG_GAIN_PROP, 16'h03FF);
    row_cfg(REG_GAIN_DERIV, 16'h03FF);
    row_cfg(REG_GAIN_INTEG, 16'h03FF);
    row_cfg(REG_SETPOINT, 16'h8000);
    row_cfg(REG_CENTER, 16'h0000);
    row_item(16'd0, 1'b0, '0, '0);
    row_item(16'd65535, 1'b0, '0, '0);              // largest error
    row_cfg(REG_SETPOINT, 16'h7FFF);
    row_cfg(REG_CENTER, 16'hFFFF);
    row_item(16'd0, 1'b0, '0, '0);                  // most negative error
    row_item(16'd65535, 1'b0, '0, '0);
    row_cfg(REG_GAIN_PROP, 16'd0);
    row_cfg(REG_GAIN_DERIV, 16'd0);
    row_cfg(REG_GAIN_INTEG, 16'd0);
    row_item(16'd12345, 1'b1, 16'd0, 16'd0);
    row_item(16'd65535, 1'b1, 16'd0, 16'd0);
    row_cfg(REG_GAIN_PROP, 16'd1);
    row_cfg(REG_NONE, 16'hFFFF);
    row_item(16'd32767, 1'b0, '0, '0);
    row_item(16'd0, 1'b0, '0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_cfg) begin
        wait_idle();
        write_reg(r.idx, r.data);
      end else begin
        send_count(r.data, r.typed, r.drive);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_reg(REG_SETPOINT, rand_setpoint());
      write_reg(REG_GAIN_PROP, rand_reg(GAIN_W));
      write_reg(REG_GAIN_DERIV, rand_reg(GAIN_W));
      write_reg(REG_GAIN_INTEG, rand_reg(GAIN_W));
      write_reg(REG_ZONE, rand_reg(16));
      write_reg(REG_LIMIT, $urandom_range(0, 1) ? 16'hFFFF : rand_reg(16));
      write_reg(REG_CENTER, rand_reg(16));
      if (p % 3 == 0) write_reg(REG_NONE, CFG_W'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_count(rand_count(), 1'b0, '0);
    end

    // integral at the edge of the zone: climb, fall back through zero and past it,
    // then return; with only ki set the drive tracks the integral around zero
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_GAIN_PROP, 16'd0);
    write_reg(REG_GAIN_DERIV, 16'd0);
    write_reg(REG_GAIN_INTEG, 16'd1);
    write_reg(REG_ZONE, 16'hFFFF);
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_SETPOINT, 16'h8000);
    write_reg(REG_CENTER, 16'h0000);
    hold_count(16'd32766, RUN_ITEMS);
    wait_idle();
    write_reg(REG_SETPOINT, 16'h7FFF);
    write_reg(REG_CENTER, 16'h7FFF);
    hold_count(16'd0, 2 * RUN_ITEMS);
    wait_idle();
    write_reg(REG_SETPOINT, 16'h8000);
    write_reg(REG_CENTER, 16'h0000);
    hold_count(16'd32766, RUN_ITEMS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
